/* hdl/segment_box_slab_test_core_defines.svh */
// ---------------------------------------------------------------------------
// Segment/box slab test: assertion macros
// Concurrent assertion wrappers shared by the core. Define NO_ASSERTIONS to
// compile them out.
// ---------------------------------------------------------------------------
`ifndef SEGMENT_BOX_SLAB_TEST_CORE_DEFINES_SVH
`define SEGMENT_BOX_SLAB_TEST_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// check that holds only out of reset
`define SBST_ASSERT_ACTIVE(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check that holds at every edge, reset included
`define SBST_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SBST_ASSERT_ACTIVE(label, clk, rst_n, prop, msg)
`define SBST_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

/* hdl/sbst_pkg.sv */
// ---------------------------------------------------------------------------
// Segment/box slab test package
// Shared constants and the status bundle passed between pipeline parts.
// ---------------------------------------------------------------------------
package sbst_pkg;

  localparam int COORD_BITS_DEF = 16;

  // per-request slab status after the setup stages
  typedef struct packed {
    logic zero_x;   // no motion along x
    logic zero_y;   // no motion along y
    logic slab_ok;  // every zero-motion axis has its start inside the slab
  } sbst_flags_t;

endpackage

/* hdl/sbst_prep.sv */
// ---------------------------------------------------------------------------
// Segment/box slab test: slab setup
// Two stages: slab offsets and deltas, then orientation so every delta is
// non-negative, plus the inside check for axes without motion.
// ---------------------------------------------------------------------------
module sbst_prep #(
  parameter int COORD_BITS = sbst_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_vld,
  input  logic signed [COORD_BITS-1:0] start_x,
  input  logic signed [COORD_BITS-1:0] start_y,
  input  logic signed [COORD_BITS-1:0] end_x,
  input  logic signed [COORD_BITS-1:0] end_y,
  input  logic signed [COORD_BITS-1:0] left,
  input  logic signed [COORD_BITS-1:0] top,
  input  logic        [COORD_BITS-2:0] width,
  input  logic        [COORD_BITS-2:0] height,
  output logic                         out_vld,
  output logic signed [COORD_BITS+2:0] ent [2],
  output logic signed [COORD_BITS+2:0] ext [2],
  output logic signed [COORD_BITS+2:0] dlt [2],
  output sbst_pkg::sbst_flags_t        flags
);

  localparam int AW = COORD_BITS + 3;

  logic signed [AW-1:0] lo_nxt [2];
  logic signed [AW-1:0] hi_nxt [2];
  logic signed [AW-1:0] d_nxt  [2];
  logic signed [AW-1:0] a1_r   [2];
  logic signed [AW-1:0] b1_r   [2];
  logic signed [AW-1:0] d1_r   [2];
  logic                 v1_r;
  logic signed [AW-1:0] a2_nxt [2];
  logic signed [AW-1:0] b2_nxt [2];
  logic signed [AW-1:0] d2_nxt [2];
  logic signed [AW-1:0] a2_r   [2];
  logic signed [AW-1:0] b2_r   [2];
  logic signed [AW-1:0] d2_r   [2];
  logic                 v2_r;
  logic                 zero    [2];
  logic                 in_slab [2];
  sbst_pkg::sbst_flags_t flags_nxt;
  sbst_pkg::sbst_flags_t flags_r;

  // stage 1: offsets of both slab bounds from the start, and the delta
  always_comb begin
    lo_nxt[0] = AW'(left) - AW'(start_x);
    lo_nxt[1] = AW'(top)  - AW'(start_y);
    hi_nxt[0] = AW'(left) + AW'($signed({1'b0, width}))  - AW'(start_x);
    hi_nxt[1] = AW'(top)  + AW'($signed({1'b0, height})) - AW'(start_y);
    d_nxt[0]  = AW'(end_x) - AW'(start_x);
    d_nxt[1]  = AW'(end_y) - AW'(start_y);
  end

  // stage 2: flip axes with negative delta so entry and exit swap
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      zero[i]    = (d1_r[i] == '0);
      in_slab[i] = (a1_r[i] <= 0) && (b1_r[i] >= 0);
      if (d1_r[i] < 0) begin
        a2_nxt[i] = -b1_r[i];
        b2_nxt[i] = -a1_r[i];
        d2_nxt[i] = -d1_r[i];
      end else begin
        a2_nxt[i] = a1_r[i];
        b2_nxt[i] = b1_r[i];
        d2_nxt[i] = d1_r[i];
      end
    end
    flags_nxt.zero_x  = zero[0];
    flags_nxt.zero_y  = zero[1];
    flags_nxt.slab_ok = (!zero[0] || in_slab[0]) && (!zero[1] || in_slab[1]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_vld;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1_r    <= lo_nxt;
      b1_r    <= hi_nxt;
      d1_r    <= d_nxt;
      a2_r    <= a2_nxt;
      b2_r    <= b2_nxt;
      d2_r    <= d2_nxt;
      flags_r <= flags_nxt;
    end
  end

  assign out_vld = v2_r;
  assign ent     = a2_r;
  assign ext     = b2_r;
  assign dlt     = d2_r;
  assign flags   = flags_r;

endmodule

/* hdl/sbst_cross.sv */
// ---------------------------------------------------------------------------
// Segment/box slab test: interval check
// Stage 3 forms the cross products between the two axes and the checks
// against [0,1]; stage 4 compares the products and holds the result.
// ---------------------------------------------------------------------------
module sbst_cross #(
  parameter int COORD_BITS = sbst_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_vld,
  input  logic signed [COORD_BITS+2:0] ent [2],
  input  logic signed [COORD_BITS+2:0] ext [2],
  input  logic signed [COORD_BITS+2:0] dlt [2],
  input  sbst_pkg::sbst_flags_t        flags,
  output logic                         out_vld,
  output logic                         hit
);

  localparam int AW = COORD_BITS + 3;
  localparam int PW = 2 * AW;

  logic                 axis_ok [2];
  logic                 zero    [2];
  logic signed [PW-1:0] p_nxt   [4];
  logic signed [PW-1:0] p_r     [4];
  logic                 simple_ok_nxt;
  logic                 simple_ok_r;
  logic                 both_r;
  logic                 v3_r;
  logic                 hit_nxt;
  logic                 hit_r;
  logic                 v4_r;

  always_comb begin
    zero[0] = flags.zero_x;
    zero[1] = flags.zero_y;
    for (int i = 0; i < 2; i++) begin
      // entry at or below 1, exit at or above 0, entry not past exit
      axis_ok[i] = zero[i] ||
                   ((ext[i] >= 0) && (ent[i] <= dlt[i]) && (ent[i] <= ext[i]));
    end
    simple_ok_nxt = flags.slab_ok && axis_ok[0] && axis_ok[1];
    // entry of one axis against exit of the other, cross multiplied
    p_nxt[0] = PW'(ent[0]) * PW'(dlt[1]);
    p_nxt[1] = PW'(ext[1]) * PW'(dlt[0]);
    p_nxt[2] = PW'(ent[1]) * PW'(dlt[0]);
    p_nxt[3] = PW'(ext[0]) * PW'(dlt[1]);
  end

  always_comb begin
    hit_nxt = simple_ok_r && (!both_r || ((p_r[0] <= p_r[1]) && (p_r[2] <= p_r[3])));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v3_r <= in_vld;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r         <= p_nxt;
      simple_ok_r <= simple_ok_nxt;
      both_r      <= !flags.zero_x && !flags.zero_y;
      hit_r       <= hit_nxt;
    end
  end

  assign out_vld = v4_r;
  assign hit     = hit_r;

endmodule

/* hdl/segment_box_slab_test_core.sv */
// A request passes four register stages (slab offsets, orientation, cross
// products, compare/output) in order. The stages advance together and take
// 1 request per cycle while the result side is not stalled.
// A stall on the result side freezes all stages; nothing is dropped.
// Reset (rst_n low, synchronous) clears every stage valid bit; data is not reset.
// ---------------------------------------------------------------------------
// Segment versus axis-aligned box intersection, slab test
// Exact integer slab test: parameter interval narrowed per axis, compared by
// cross multiplication.
// ---------------------------------------------------------------------------
`include "segment_box_slab_test_core_defines.svh"

module segment_box_slab_test_core #(
  parameter int COORD_BITS = sbst_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] in_seg_start_x,
  input  logic signed [COORD_BITS-1:0] in_seg_start_y,
  input  logic signed [COORD_BITS-1:0] in_seg_end_x,
  input  logic signed [COORD_BITS-1:0] in_seg_end_y,
  input  logic signed [COORD_BITS-1:0] in_box_left,
  input  logic signed [COORD_BITS-1:0] in_box_top,
  input  logic        [COORD_BITS-2:0] in_box_width,
  input  logic        [COORD_BITS-2:0] in_box_height,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_hit
);

  logic                         en;
  logic                         prep_vld;
  logic signed [COORD_BITS+2:0] ent [2];
  logic signed [COORD_BITS+2:0] ext [2];
  logic signed [COORD_BITS+2:0] dlt [2];
  sbst_pkg::sbst_flags_t        flags;

  // advance the whole pipe unless a finished result is held
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  sbst_prep #(
    .COORD_BITS (COORD_BITS)
  ) u_prep (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (in_valid),
    .start_x (in_seg_start_x),
    .start_y (in_seg_start_y),
    .end_x   (in_seg_end_x),
    .end_y   (in_seg_end_y),
    .left    (in_box_left),
    .top     (in_box_top),
    .width   (in_box_width),
    .height  (in_box_height),
    .out_vld (prep_vld),
    .ent     (ent),
    .ext     (ext),
    .dlt     (dlt),
    .flags   (flags)
  );

  sbst_cross #(
    .COORD_BITS (COORD_BITS)
  ) u_cross (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (prep_vld),
    .ent     (ent),
    .ext     (ext),
    .dlt     (dlt),
    .flags   (flags),
    .out_vld (out_valid),
    .hit     (out_hit)
  );

  `SBST_ASSERT_ACTIVE(a_stall_freezes, clk, rst_n, !in_ready |=> $stable(prep_vld) && out_valid, "pipe moved during stall")
  `SBST_ASSERT_ACTIVE(a_empty_takes, clk, rst_n, !out_valid |-> in_ready, "request refused with empty output")
  `SBST_ASSERT_ALWAYS(a_reset_clears, clk, !$past(rst_n) |-> !out_valid && !prep_vld, "valid survived reset")
  `SBST_ASSERT_ACTIVE(a_dlt_positive, clk, rst_n, prep_vld && !flags.zero_x |-> dlt[0] > 0, "x delta not oriented")

endmodule

/* bench/sbst_hit_checker.sv */
// ---------------------------------------------------------------------------
// Segment/box slab test: result checker
// Watches both channels of the core. Each accepted request is turned into an
// expected hit flag by an exact integer slab test; each accepted result is
// compared with the oldest expected flag. Mismatches are counted for the top.
// ---------------------------------------------------------------------------
module sbst_hit_checker #(
  parameter int COORD_BITS = sbst_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] in_seg_start_x,
  input  logic signed [COORD_BITS-1:0] in_seg_start_y,
  input  logic signed [COORD_BITS-1:0] in_seg_end_x,
  input  logic signed [COORD_BITS-1:0] in_seg_end_y,
  input  logic signed [COORD_BITS-1:0] in_box_left,
  input  logic signed [COORD_BITS-1:0] in_box_top,
  input  logic        [COORD_BITS-2:0] in_box_width,
  input  logic        [COORD_BITS-2:0] in_box_height,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic                         out_hit,
  output int                           mismatch_count,
  output int                           pending_hits
);

  bit expected_hits[$];

  // Interval [0,1] narrowed by each moving axis; p/q <= r/s checked as p*s <= r*q.
  function automatic bit slab_hit(
    input logic signed [COORD_BITS-1:0] sx, sy, ex, ey, left, top,
    input logic        [COORD_BITS-2:0] width, height
  );
    longint org[2], delta[2], lo_edge[2], hi_edge[2];
    longint enter_num[3], enter_den[3], leave_num[3], leave_den[3];
    longint a, b, d, t;
    int n_enter, n_leave;
    bit hit;
    org[0] = longint'(sx);
    org[1] = longint'(sy);
    delta[0] = longint'(ex) - org[0];
    delta[1] = longint'(ey) - org[1];
    lo_edge[0] = longint'(left);
    lo_edge[1] = longint'(top);
    hi_edge[0] = lo_edge[0] + longint'({1'b0, width});
    hi_edge[1] = lo_edge[1] + longint'({1'b0, height});
    enter_num[0] = 0;
    enter_den[0] = 1;
    leave_num[0] = 1;
    leave_den[0] = 1;
    n_enter = 1;
    n_leave = 1;
    hit = 1'b1;
    for (int ax = 0; ax < 2; ax++) begin
      a = lo_edge[ax] - org[ax];
      b = hi_edge[ax] - org[ax];
      d = delta[ax];
      if (d == 0) begin
        // no motion: start must sit inside this slab
        if (a > 0 || b < 0) hit = 1'b0;
      end else begin
        if (d < 0) begin
          // flip so the denominator is positive; entry and exit swap
          t = -a;
          a = -b;
          b = t;
          d = -d;
        end
        enter_num[n_enter] = a;
        enter_den[n_enter] = d;
        n_enter++;
        leave_num[n_leave] = b;
        leave_den[n_leave] = d;
        n_leave++;
      end
    end
    for (int i = 0; i < n_enter; i++)
      for (int j = 0; j < n_leave; j++)
        if (enter_num[i] * leave_den[j] > leave_num[j] * enter_den[i]) hit = 1'b0;
    return hit;
  endfunction

  always @(posedge clk) begin : watch
    bit want;
    int errs;
    errs = 0;
    if (!rst_n) begin
      expected_hits.delete();
      mismatch_count <= 0;
      pending_hits <= 0;
    end else begin
      if (in_valid && in_ready)
        expected_hits.push_back(slab_hit(in_seg_start_x, in_seg_start_y, in_seg_end_x,
                                         in_seg_end_y, in_box_left, in_box_top,
                                         in_box_width, in_box_height));
      if (out_valid && out_ready) begin
        if (expected_hits.size() == 0) begin
          $display("%0t: result with no request pending, expected none actual %0b",
                   $time, out_hit);
          errs++;
        end else begin
          want = expected_hits.pop_front();
          if (out_hit !== want) begin
            $display("%0t: hit mismatch, expected %0b actual %0b", $time, want, out_hit);
            errs++;
          end
        end
      end
      mismatch_count <= mismatch_count + errs;
      pending_hits <= expected_hits.size();
    end
  end

endmodule

/* bench/tb_segment_box_slab_test_core.sv */
// ---------------------------------------------------------------------------
// Segment/box slab test core testbench
// Drives directed corner cases and about 1500 random segment/box requests
// with random gaps and result stalls, a long result hold-off and a full
// drain, while the checker predicts and compares every hit flag.
// ---------------------------------------------------------------------------
module tb_segment_box_slab_test_core;

  localparam int CB              = sbst_pkg::COORD_BITS_DEF;
  localparam int RANDOM_REQUESTS = 1500;
  localparam int IDLE_PCT        = 24;
  localparam int HOLD_CYCLES     = 60;
  localparam int DRAIN_CYCLES    = 12;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic signed [CB-1:0] in_seg_start_x, in_seg_start_y, in_seg_end_x, in_seg_end_y;
  logic signed [CB-1:0] in_box_left, in_box_top;
  logic        [CB-2:0] in_box_width, in_box_height;
  logic                 out_valid;
  logic                 out_ready;
  logic                 out_hit;
  int                   mismatch_count;
  int                   pending_hits;
  bit                   calm = 1'b0;
  bit                   hold_req = 1'b0;

  segment_box_slab_test_core #(.COORD_BITS(CB)) DUT (
    .clk, .rst_n, .in_valid, .in_ready,
    .in_seg_start_x, .in_seg_start_y, .in_seg_end_x, .in_seg_end_y,
    .in_box_left, .in_box_top, .in_box_width, .in_box_height,
    .out_valid, .out_ready, .out_hit
  );

  sbst_hit_checker #(.COORD_BITS(CB)) u_checker (
    .clk, .rst_n, .in_valid, .in_ready,
    .in_seg_start_x, .in_seg_start_y, .in_seg_end_x, .in_seg_end_y,
    .in_box_left, .in_box_top, .in_box_width, .in_box_height,
    .out_valid, .out_ready, .out_hit,
    .mismatch_count, .pending_hits
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // result side: random stalls, a calm stretch, and one long hold-off
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  task automatic send_request(input int sx, sy, ex, ey, left, top, width, height);
    in_valid       <= 1'b1;
    in_seg_start_x <= CB'(sx);
    in_seg_start_y <= CB'(sy);
    in_seg_end_x   <= CB'(ex);
    in_seg_end_y   <= CB'(ey);
    in_box_left    <= CB'(left);
    in_box_top     <= CB'(top);
    in_box_width   <= (CB-1)'(width);
    in_box_height  <= (CB-1)'(height);
    do @(posedge clk); while (!in_ready);
    if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  // the pending count is a registered copy of the checker queue size
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_hits != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic int jitter(input int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  // a coordinate on, just outside, or inside one slab of the box
  function automatic int slab_point(input int lo, input int ext);
    case ($urandom_range(0, 4))
      0:       return lo;
      1:       return lo + ext;
      2:       return lo - 1;
      3:       return lo + ext + 1;
      default: return lo + int'($urandom_range(0, ext));
    endcase
  endfunction

  function automatic int extreme_coord();
    case ($urandom_range(0, 4))
      0:       return -32768;
      1:       return -1;
      2:       return 0;
      3:       return 1;
      default: return 32767;
    endcase
  endfunction

  task automatic random_request();
    int mode, span, cx, cy, left, top, width, height, sx, sy, ex, ey;
    mode   = $urandom_range(0, 99);
    span   = 1 << $urandom_range(2, 14);
    cx     = int'($urandom_range(0, 65535)) - 32768;
    cy     = int'($urandom_range(0, 65535)) - 32768;
    width  = $urandom_range(0, span);
    height = $urandom_range(0, span);
    left   = cx + jitter(span);
    top    = cy + jitter(span);
    sx     = cx + jitter(2 * span);
    sy     = cy + jitter(2 * span);
    ex     = cx + jitter(2 * span);
    ey     = cy + jitter(2 * span);
    if (mode < 40) begin
      // segment and box in the same neighborhood: keep as drawn
    end else if (mode < 55) begin
      sx     = $urandom;
      sy     = $urandom;
      ex     = $urandom;
      ey     = $urandom;
      left   = $urandom;
      top    = $urandom;
      width  = $urandom;
      height = $urandom;
    end else if (mode < 70) begin
      case ($urandom_range(0, 2))
        0: begin
          ex = sx;
          ey = sy;
        end
        1:       ex = sx;
        default: ey = sy;
      endcase
    end else if (mode < 85) begin
      sx = slab_point(left, width);
      sy = slab_point(top, height);
      ex = slab_point(left, width);
      ey = slab_point(top, height);
    end else begin
      sx     = extreme_coord();
      sy     = extreme_coord();
      ex     = extreme_coord();
      ey     = extreme_coord();
      left   = extreme_coord();
      top    = extreme_coord();
      width  = ($urandom_range(0, 2) == 2) ? 32767 : $urandom_range(0, 1);
      height = ($urandom_range(0, 2) == 2) ? 32767 : $urandom_range(0, 1);
    end
    send_request(sx, sy, ex, ey, left, top, width, height);
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_seg_start_x = '0;
    in_seg_start_y = '0;
    in_seg_end_x   = '0;
    in_seg_end_y   = '0;
    in_box_left    = '0;
    in_box_top     = '0;
    in_box_width   = '0;
    in_box_height  = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    send_request(0, 0, 10, 10, 0, 0, 10, 10);
    // degenerate segments: inside, on the corner, outside
    send_request(5, 5, 5, 5, 0, 0, 10, 10);
    send_request(10, 10, 10, 10, 0, 0, 10, 10);
    send_request(11, 5, 11, 5, 0, 0, 10, 10);
    // no motion along one axis: inside, outside, on the border
    send_request(3, -20, 3, 20, 0, 0, 10, 10);
    send_request(-1, -20, -1, 20, 0, 0, 10, 10);
    send_request(-20, 10, 20, 10, 0, 0, 10, 10);
    send_request(-20, 11, 20, 11, 0, 0, 10, 10);
    // negative deltas, stopping short, touching and just missing a corner
    send_request(20, 20, -20, -20, 0, 0, 10, 10);
    send_request(-20, -20, -1, -1, 0, 0, 10, 10);
    send_request(-5, 15, 0, 10, 0, 0, 10, 10);
    send_request(-5, 16, 0, 11, 0, 0, 10, 10);
    // flat and point boxes
    send_request(0, 5, 10, 5, 5, 0, 0, 10);
    send_request(0, 0, 10, 10, 5, 5, 0, 0);
    send_request(0, 1, 10, 11, 5, 5, 0, 0);
    // full range and boxes reaching past the coordinate range
    send_request(-32768, -32768, 32767, 32767, -32768, -32768, 32767, 32767);
    send_request(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
    send_request(-32768, 32767, 32767, -32768, 0, 0, 0, 0);
    send_request(0, 0, 0, 0, 0, 0, 0, 0);
    send_request(-1, -1, -1, -1, -1, -1, 32767, 32767);
    send_request(32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767);
    send_request(32000, 0, -32768, 0, 30000, -5, 32767, 10);
    wait_drained();

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n == 300) hold_req = 1'b1;
      calm = (n >= 600 && n < 800);
      if (n == 1000) wait_drained();
      random_request();
    end

    wait_drained();
    if (mismatch_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
